// ----- sv/trop_pkg.sv -----
package trop_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned WIN_W     = 16;
    localparam int unsigned SUB_CNT_W = 3;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned TDATA_W   = 56;

    // telnet command codes
    localparam logic [BYTE_W-1:0] CMD_IAC  = 8'd255;
    localparam logic [BYTE_W-1:0] CMD_WILL = 8'd251;
    localparam logic [BYTE_W-1:0] CMD_WONT = 8'd252;
    localparam logic [BYTE_W-1:0] CMD_DO   = 8'd253;
    localparam logic [BYTE_W-1:0] CMD_DONT = 8'd254;
    localparam logic [BYTE_W-1:0] CMD_SB   = 8'd250;
    localparam logic [BYTE_W-1:0] CMD_SE   = 8'd240;

    // option codes
    localparam logic [BYTE_W-1:0] OPT_ECHO = 8'd1;
    localparam logic [BYTE_W-1:0] OPT_SGA  = 8'd3;
    localparam logic [BYTE_W-1:0] OPT_NAWS = 8'd31;

    localparam logic [SUB_CNT_W-1:0] NAWS_LEN = 3'd4;

    localparam logic [WIN_W-1:0] COLS_RESET = 16'd80;
    localparam logic [WIN_W-1:0] ROWS_RESET = 16'd25;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ECHO  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAWS_ENABLE = 1'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_REPLY = 2'd2
    } kind_t;

    typedef enum logic [7:0] {
        PS_NORMAL = 8'b0000_0001,
        PS_IAC    = 8'b0000_0010,
        PS_WILL   = 8'b0000_0100,
        PS_WONT   = 8'b0000_1000,
        PS_DO     = 8'b0001_0000,
        PS_DONT   = 8'b0010_0000,
        PS_SB     = 8'b0100_0000,
        PS_SBNAWS = 8'b1000_0000
    } parse_state_t;

endpackage

// ----- sv/telnet_rx_option_parser.sv -----
// channel   direction  handshake               payload
// s_        in         s_tvalid / s_tready     s_tdata: rx_byte
// m_        out        m_tvalid / m_tready     m_tuser: kind; m_tdata: reply and window fields
// cfg_      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one received byte per cycle unless stalled; each gives exactly one registered result
// the parser state and window registers update in the same cycle the byte is taken
// aresetn (synchronous, active low) returns to normal data state, 80 columns, 25 rows
// a single output register: a new byte is taken whenever the output is empty or
// being taken in that same cycle, so a stalled m_ side stalls s_ only while full
module telnet_rx_option_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    // rx_byte
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [trop_pkg::BYTE_W-1:0]     s_tdata,
    // data_byte, reply_verb, reply_option, window_cols, window_rows
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [trop_pkg::TDATA_W-1:0]    m_tdata,
    // kind
    output logic [trop_pkg::KIND_W-1:0]     m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [trop_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                            cfg_data
);
    import trop_pkg::*;

    logic                   local_echo_reg;
    logic                   naws_enable_reg;
    parse_state_t           state_reg, state_next;
    logic [SUB_CNT_W-1:0]   sub_count_reg, sub_count_next;
    logic [WIN_W-1:0]       cols_reg, cols_next;
    logic [WIN_W-1:0]       rows_reg, rows_next;

    logic                   m_valid_reg;
    kind_t                  kind_reg, kind_next;
    logic [BYTE_W-1:0]      data_reg, data_next;
    logic [BYTE_W-1:0]      verb_reg, verb_next;
    logic [BYTE_W-1:0]      opt_reg, opt_next;
    logic [WIN_W-1:0]       out_cols_reg;
    logic [WIN_W-1:0]       out_rows_reg;

    logic                   in_fire;
    logic [BYTE_W-1:0]      ch;

    assign s_tready  = !m_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign ch        = s_tdata;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {out_rows_reg, out_cols_reg, opt_reg, verb_reg, data_reg};

    always_comb begin
        state_next     = state_reg;
        sub_count_next = sub_count_reg;
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        kind_next      = KIND_NONE;
        data_next      = '0;
        verb_next      = '0;
        opt_next       = '0;
        case (state_reg)
            PS_IAC: begin
                if (ch == CMD_IAC) begin
                    kind_next  = KIND_DATA;
                    data_next  = ch;
                    state_next = PS_NORMAL;
                end else if (ch == CMD_WILL) begin
                    state_next = PS_WILL;
                end else if (ch == CMD_WONT) begin
                    state_next = PS_WONT;
                end else if (ch == CMD_DO) begin
                    state_next = PS_DO;
                end else if (ch == CMD_DONT) begin
                    state_next = PS_DONT;
                end else if (ch == CMD_SB && naws_enable_reg) begin
                    state_next     = PS_SB;
                    sub_count_next = '0;
                end else begin
                    // unknown command, SE, or SB while window size is disabled is dropped
                    state_next = PS_NORMAL;
                end
            end
            PS_WILL: begin
                kind_next  = KIND_REPLY;
                opt_next   = ch;
                verb_next  = (naws_enable_reg && ch == OPT_NAWS) ? CMD_DO : CMD_DONT;
                state_next = PS_NORMAL;
            end
            PS_WONT: begin
                kind_next  = KIND_REPLY;
                opt_next   = ch;
                verb_next  = CMD_DONT;
                state_next = PS_NORMAL;
            end
            PS_DO: begin
                kind_next  = KIND_REPLY;
                opt_next   = ch;
                verb_next  = (ch == OPT_SGA || (local_echo_reg && ch == OPT_ECHO))
                             ? CMD_WONT : CMD_WILL;
                state_next = PS_NORMAL;
            end
            PS_DONT: begin
                kind_next  = KIND_REPLY;
                opt_next   = ch;
                verb_next  = CMD_WONT;
                state_next = PS_NORMAL;
            end
            PS_SB: begin
                state_next = (naws_enable_reg && ch == OPT_NAWS) ? PS_SBNAWS : PS_NORMAL;
            end
            PS_SBNAWS: begin
                if (!naws_enable_reg) begin
                    state_next = PS_NORMAL;
                end else begin
                    // payload bytes taken raw: cols high, cols low, rows high, rows low
                    case (sub_count_reg)
                        3'd0: cols_next = {ch, cols_reg[BYTE_W-1:0]};
                        3'd1: cols_next = {cols_reg[WIN_W-1:BYTE_W], ch};
                        3'd2: rows_next = {ch, rows_reg[BYTE_W-1:0]};
                        3'd3: rows_next = {rows_reg[WIN_W-1:BYTE_W], ch};
                        default: ;
                    endcase
                    sub_count_next = sub_count_reg + 3'd1;
                    if (sub_count_next == NAWS_LEN) begin
                        state_next = PS_NORMAL;
                    end
                end
            end
            default: begin
                if (ch == CMD_IAC) begin
                    state_next = PS_IAC;
                end else begin
                    kind_next = KIND_DATA;
                    data_next = ch;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_echo_reg  <= 1'b1;
            naws_enable_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_LOCAL_ECHO) begin
                local_echo_reg <= cfg_data;
            end
            if (cfg_index == CFG_NAWS_ENABLE) begin
                naws_enable_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= PS_NORMAL;
            sub_count_reg <= '0;
            cols_reg      <= COLS_RESET;
            rows_reg      <= ROWS_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (in_fire) begin
                state_reg     <= state_next;
                sub_count_reg <= sub_count_next;
                cols_reg      <= cols_next;
                rows_reg      <= rows_next;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with every accepted byte
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            kind_reg     <= kind_next;
            data_reg     <= data_next;
            verb_reg     <= verb_next;
            opt_reg      <= opt_next;
            out_cols_reg <= cols_next;
            out_rows_reg <= rows_next;
        end
    end

    a_reply_verb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && kind_reg == KIND_REPLY |->
            verb_reg == CMD_WILL || verb_reg == CMD_WONT ||
            verb_reg == CMD_DO || verb_reg == CMD_DONT)
        else $error("reply verb out of range");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && kind_reg == KIND_NONE |->
            data_reg == '0 && verb_reg == '0 && opt_reg == '0)
        else $error("empty result carries payload");

    a_sub_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == PS_SBNAWS |-> sub_count_reg < NAWS_LEN)
        else $error("naws payload count overrun");

    a_win_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_fire |=> $stable(cols_reg) && $stable(rows_reg))
        else $error("window size changed without input");

    a_out_window: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> out_cols_reg == cols_reg && out_rows_reg == rows_reg)
        else $error("reported window size differs from state");

endmodule

// ----- test/tb_top.sv -----
module tb_top;
    import trop_pkg::*;

    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned HOLD_AT     = 700;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_BYTES = 250;
    localparam int unsigned PRINT_CAP   = 40;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] reply_verb;
        logic [BYTE_W-1:0] reply_option;
        logic [WIN_W-1:0]  cols;
        logic [WIN_W-1:0]  rows;
    } parser_result_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic                 val;
        logic [BYTE_W-1:0]    rx;
        bit                   typed;
        parser_result_t       res;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic                 cfg_data;

    telnet_rx_option_parser u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    parse_state_t         ps_now   = PS_NORMAL;
    logic [SUB_CNT_W-1:0] sub_idx  = '0;
    logic [WIN_W-1:0]     win_cols = COLS_RESET;
    logic [WIN_W-1:0]     win_rows = ROWS_RESET;
    logic                 echo_on  = 1'b1;
    logic                 naws_on  = 1'b1;

    parser_result_t results_due[$];
    stim_row_t      stim_table[$];
    parser_result_t typed_res;
    logic           typed_due;
    parser_result_t got_res;
    parser_result_t want_res;
    int unsigned    mismatch_count = 0;
    int unsigned    bytes_sent = 0;
    int unsigned    quiet_cycles = 0;
    int unsigned    tx_run_left = 0;
    bit             tx_calm = 0;

    function automatic parser_result_t parse_byte(input logic [BYTE_W-1:0] ch);
        parser_result_t r;
        r = '0;
        r.kind = KIND_NONE;
        case (ps_now)
            PS_IAC: begin
                if (ch == CMD_IAC) begin
                    r.kind = KIND_DATA;
                    r.data_byte = ch;
                    ps_now = PS_NORMAL;
                end else if (ch == CMD_WILL) begin
                    ps_now = PS_WILL;
                end else if (ch == CMD_WONT) begin
                    ps_now = PS_WONT;
                end else if (ch == CMD_DO) begin
                    ps_now = PS_DO;
                end else if (ch == CMD_DONT) begin
                    ps_now = PS_DONT;
                end else if (ch == CMD_SB && naws_on) begin
                    ps_now = PS_SB;
                    sub_idx = '0;
                end else begin
                    ps_now = PS_NORMAL;
                end
            end
            PS_WILL: begin
                r.kind = KIND_REPLY;
                r.reply_option = ch;
                r.reply_verb = (naws_on && ch == OPT_NAWS) ? CMD_DO : CMD_DONT;
                ps_now = PS_NORMAL;
            end
            PS_WONT: begin
                r.kind = KIND_REPLY;
                r.reply_option = ch;
                r.reply_verb = CMD_DONT;
                ps_now = PS_NORMAL;
            end
            PS_DO: begin
                r.kind = KIND_REPLY;
                r.reply_option = ch;
                if (ch == OPT_SGA || (echo_on && ch == OPT_ECHO)) begin
                    r.reply_verb = CMD_WONT;
                end else begin
                    r.reply_verb = CMD_WILL;
                end
                ps_now = PS_NORMAL;
            end
            PS_DONT: begin
                r.kind = KIND_REPLY;
                r.reply_option = ch;
                r.reply_verb = CMD_WONT;
                ps_now = PS_NORMAL;
            end
            PS_SB: begin
                ps_now = (naws_on && ch == OPT_NAWS) ? PS_SBNAWS : PS_NORMAL;
            end
            PS_SBNAWS: begin
                if (!naws_on) begin
                    ps_now = PS_NORMAL;
                end else begin
                    // payload order: cols high, cols low, rows high, rows low
                    case (sub_idx)
                        3'd0: win_cols[15:8] = ch;
                        3'd1: win_cols[7:0]  = ch;
                        3'd2: win_rows[15:8] = ch;
                        3'd3: win_rows[7:0]  = ch;
                        default: ;
                    endcase
                    sub_idx = sub_idx + 1'b1;
                    if (sub_idx == NAWS_LEN) ps_now = PS_NORMAL;
                end
            end
            default: begin
                if (ch == CMD_IAC) begin
                    ps_now = PS_IAC;
                end else begin
                    r.kind = KIND_DATA;
                    r.data_byte = ch;
                end
            end
        endcase
        r.cols = win_cols;
        r.rows = win_rows;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP)
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // wait drawn per transaction; runs of zero waits give back-to-back stretches
    function automatic int unsigned draw_wait(inout int unsigned run_left, inout bit calm);
        if (run_left == 0) begin
            run_left = $urandom_range(8, 64);
            calm = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_option();
        case ($urandom_range(0, 5))
            0: return OPT_ECHO;
            1: return OPT_SGA;
            2: return OPT_NAWS;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void row_byte(input logic [BYTE_W-1:0] rx);
        stim_row_t row;
        row = '{default: '0};
        row.rx = rx;
        stim_table.push_back(row);
    endfunction

    function automatic void row_typed(input logic [BYTE_W-1:0] rx, input kind_t k,
                                      input logic [BYTE_W-1:0] d, input logic [BYTE_W-1:0] v,
                                      input logic [BYTE_W-1:0] o, input logic [WIN_W-1:0] c,
                                      input logic [WIN_W-1:0] r);
        stim_row_t row;
        row = '{default: '0};
        row.rx = rx;
        row.typed = 1'b1;
        row.res = '{kind: k, data_byte: d, reply_verb: v, reply_option: o, cols: c, rows: r};
        stim_table.push_back(row);
    endfunction

    function automatic void row_cfg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        stim_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.val = val;
        stim_table.push_back(row);
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] rx, input logic typed = 1'b0,
                             input parser_result_t t = '0);
        int unsigned gap;
        gap = draw_wait(tx_run_left, tx_calm);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= rx;
        typed_due <= typed;
        typed_res <= t;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_sequence();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send_byte(BYTE_W'($urandom_range(0, 254)));
        end else if (pick < 50) begin
            send_byte(CMD_IAC);
            send_byte(CMD_IAC);
        end else if (pick < 75) begin
            send_byte(CMD_IAC);
            send_byte(BYTE_W'(CMD_WILL + $urandom_range(0, 3)));
            send_byte(pick_option());
        end else if (pick < 85) begin
            send_byte(CMD_IAC);
            send_byte(CMD_SB);
            send_byte(OPT_NAWS);
            repeat (4) send_byte(BYTE_W'($urandom_range(0, 255)));
            send_byte(CMD_IAC);
            send_byte(CMD_SE);
        end else if (pick < 90) begin
            send_byte(CMD_IAC);
            send_byte(CMD_SB);
            send_byte(BYTE_W'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 3)) send_byte(BYTE_W'($urandom_range(0, 254)));
        end else if (pick < 95) begin
            send_byte(CMD_IAC);
            send_byte(BYTE_W'($urandom_range(0, 255)));
        end else begin
            send_byte(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_res = '{kind: kind_t'(m_tuser), data_byte: m_tdata[7:0],
                            reply_verb: m_tdata[15:8], reply_option: m_tdata[23:16],
                            cols: m_tdata[39:24], rows: m_tdata[55:40]};
                if (results_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with nothing expected, kind %0d data %0h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want_res = results_due.pop_front();
                    check_field("kind", 32'(want_res.kind), 32'(got_res.kind));
                    check_field("data_byte", 32'(want_res.data_byte),
                                32'(got_res.data_byte));
                    check_field("reply_verb", 32'(want_res.reply_verb),
                                32'(got_res.reply_verb));
                    check_field("reply_option", 32'(want_res.reply_option),
                                32'(got_res.reply_option));
                    check_field("window_cols", 32'(want_res.cols), 32'(got_res.cols));
                    check_field("window_rows", 32'(want_res.rows), 32'(got_res.rows));
                end
            end
            if (s_tvalid && s_tready) begin
                want_res = parse_byte(s_tdata);
                results_due.push_back(typed_due ? typed_res : want_res);
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_LOCAL_ECHO) echo_on = cfg_data;
                else if (cfg_index == CFG_NAWS_ENABLE) naws_on = cfg_data;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side, with one long hold-off so the output register fills and s_tready drops
    initial begin
        int unsigned stall;
        int unsigned taken;
        int unsigned rx_run_left;
        bit          rx_calm;
        m_tready = 1'b0;
        taken = 0;
        rx_run_left = 0;
        rx_calm = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = (taken == HOLD_AT) ? HOLD_CYCLES : draw_wait(rx_run_left, rx_calm);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
            @(negedge aclk);
        end
    end

    initial begin
        stim_row_t   row;
        logic        echo_val;
        logic        naws_val;
        int unsigned phase_end;

        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = 1'b0;
        typed_due = 1'b0;
        typed_res = '0;
        aresetn   = 1'b0;

        // plain zero data byte and IAC IAC
        row_typed(8'h00, KIND_DATA, 8'h00, '0, '0, COLS_RESET, ROWS_RESET);
        row_typed(CMD_IAC, KIND_NONE, '0, '0, '0, COLS_RESET, ROWS_RESET);
        row_typed(CMD_IAC, KIND_DATA, CMD_IAC, '0, '0, COLS_RESET, ROWS_RESET);
        // each verb
        row_byte(CMD_IAC); row_byte(CMD_WILL);
        row_typed(OPT_NAWS, KIND_REPLY, '0, CMD_DO, OPT_NAWS, COLS_RESET, ROWS_RESET);
        row_byte(CMD_IAC); row_byte(CMD_WILL); row_byte(OPT_ECHO);
        row_byte(CMD_IAC); row_byte(CMD_WONT); row_byte(OPT_SGA);
        row_byte(CMD_IAC); row_byte(CMD_DO);
        row_typed(OPT_SGA, KIND_REPLY, '0, CMD_WONT, OPT_SGA, COLS_RESET, ROWS_RESET);
        row_byte(CMD_IAC); row_byte(CMD_DO); row_byte(OPT_ECHO);
        row_byte(CMD_IAC); row_byte(CMD_DO); row_byte(8'h80);
        row_byte(CMD_IAC); row_byte(CMD_DONT); row_byte(8'hff);
        // unknown command, lone SE, SB for some other option
        row_byte(CMD_IAC); row_byte(8'hf1);
        row_byte(CMD_IAC); row_byte(CMD_SE);
        row_byte(CMD_IAC); row_byte(CMD_SB); row_byte(8'h18); row_byte(8'h7f);
        // window size payload taken raw, then trailing IAC SE dropped
        row_byte(CMD_IAC); row_byte(CMD_SB); row_byte(OPT_NAWS);
        row_byte(8'hff); row_byte(8'hff); row_byte(8'h00);
        row_typed(8'h00, KIND_NONE, '0, '0, '0, 16'hffff, 16'h0000);
        row_byte(CMD_IAC); row_byte(CMD_SE);
        // window size switched off in the middle of a payload
        row_byte(CMD_IAC); row_byte(CMD_SB); row_byte(OPT_NAWS); row_byte(8'h12);
        row_cfg(CFG_NAWS_ENABLE, 1'b0);
        row_byte(8'h34);
        row_byte(CMD_IAC); row_byte(CMD_SB);
        row_byte(CMD_IAC); row_byte(CMD_WILL); row_byte(OPT_NAWS);
        row_cfg(CFG_LOCAL_ECHO, 1'b0);
        row_byte(CMD_IAC); row_byte(CMD_DO); row_byte(OPT_ECHO);
        row_cfg(CFG_NAWS_ENABLE, 1'b1);
        row_cfg(CFG_LOCAL_ECHO, 1'b1);

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[i]) begin
            row = stim_table[i];
            if (row.is_cfg) begin
                drain_outputs();
                write_cfg(row.idx, row.val);
            end else begin
                send_byte(row.rx, row.typed, row.res);
            end
        end

        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin echo_val = 1'b1; naws_val = 1'b1; end
                1: begin echo_val = 1'b0; naws_val = 1'b1; end
                2: begin echo_val = 1'b0; naws_val = 1'b0; end
                3: begin echo_val = 1'b1; naws_val = 1'b0; end
                default: begin
                    echo_val = 1'($urandom_range(0, 1));
                    naws_val = 1'($urandom_range(0, 1));
                end
            endcase
            drain_outputs();
            write_cfg(CFG_LOCAL_ECHO, echo_val);
            write_cfg(CFG_NAWS_ENABLE, naws_val);
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) send_sequence();
            // with window size enabled, leave the parser partway into a window size payload across the next write
            send_byte(CMD_IAC);
            send_byte(CMD_SB);
            send_byte(OPT_NAWS);
            repeat ($urandom_range(0, 3)) send_byte(BYTE_W'($urandom_range(0, 255)));
        end

        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
